FILE: sv/two_level_lru_hierarchy_miss_counter_defines.svh
// Assertion macros used by the port-level checker of the LRU hierarchy miss counter.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef TWO_LEVEL_LRU_HIERARCHY_MISS_COUNTER_DEFINES_SVH
`define TWO_LEVEL_LRU_HIERARCHY_MISS_COUNTER_DEFINES_SVH

// same-cycle implication
`define TLH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication into the next cycle
`define TLH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/tlh_pkg.sv
// Package of the two-level LRU hierarchy miss counter: widths and default sizes.
// No dependencies.
package tlh_pkg;
	localparam int NEAR_WAYS_DEF = 8;
	localparam int FAR_WAYS_DEF  = 32;
	localparam int LINE_SIZE_DEF = 64;
	localparam int ADDR_BITS_DEF = 48;
	localparam int CNT_W         = 32;
endpackage

FILE: sv/tlh_if.sv
// Valid/ready channel interfaces of the LRU hierarchy miss counter.
// Depends on tlh_pkg.
interface tlh_in_if #(parameter int AW = tlh_pkg::ADDR_BITS_DEF);
	logic          valid;
	logic          ready;
	logic [AW-1:0] address;
	logic          first_access;
	logic          last_access;
	modport source (output valid, address, first_access, last_access, input ready);
	modport sink (input valid, address, first_access, last_access, output ready);
endinterface

interface tlh_out_if;
	logic                       valid;
	logic                       ready;
	logic                       inclusive_miss;
	logic                       exclusive_miss;
	logic [tlh_pkg::CNT_W-1:0]  inclusive_total;
	logic [tlh_pkg::CNT_W-1:0]  exclusive_total;
	logic                       last_result;
	modport source (output valid, inclusive_miss, exclusive_miss, inclusive_total,
		exclusive_total, last_result, input ready);
	modport sink (input valid, inclusive_miss, exclusive_miss, inclusive_total,
		exclusive_total, last_result, output ready);
endinterface

FILE: sv/two_level_lru_hierarchy_miss_counter.sv
// Two-level LRU hierarchy miss counter, inclusive and exclusive side by side.
// Input channel "in" carries one byte address per transaction plus first/last marks;
// output channel "out" returns one result per transaction: miss flags of both
// hierarchies and their running saturating miss counts, and an echo of last_access.
// Each transaction passes the input register, then the result register. Throughput:
// one transaction per cycle while the receiver takes results; all tag compares and rank
// updates of both hierarchies happen in the single stage between the two registers.
// first_access clears both hierarchies and counts before its own access is played.
// Reset empties all levels and zeroes the counts; no clearing pass is needed.
// When the receiver stalls, the result register holds and the input register
// keeps one more transaction, then in.ready drops until the result is taken.
// The connected input interface must be built with AW equal to ADDR_BITS;
// LINE_SIZE must be a power of two.
module two_level_lru_hierarchy_miss_counter #(
	parameter int NEAR_WAYS = tlh_pkg::NEAR_WAYS_DEF,
	parameter int FAR_WAYS  = tlh_pkg::FAR_WAYS_DEF,
	parameter int LINE_SIZE = tlh_pkg::LINE_SIZE_DEF,
	parameter int ADDR_BITS = tlh_pkg::ADDR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tlh_in_if.sink    in,
	tlh_out_if.source out
);
	import tlh_pkg::*;

	localparam int LSH = $clog2(LINE_SIZE);
	localparam int TW  = ADDR_BITS - LSH;
	localparam int MW  = (NEAR_WAYS > FAR_WAYS) ? NEAR_WAYS : FAR_WAYS;
	localparam int RW  = (MW > 1) ? $clog2(MW) : 1;
	localparam int NRW = (NEAR_WAYS > 1) ? $clog2(NEAR_WAYS) : 1;
	localparam int FRW = (FAR_WAYS > 1) ? $clog2(FAR_WAYS) : 1;

	typedef struct packed {
		logic [MW-1:0]         v;
		logic [MW-1:0][RW-1:0] r;
		logic [MW-1:0][TW-1:0] t;
	} lvl_t;

	typedef struct packed {
		lvl_t          l;
		logic          ev;
		logic [TW-1:0] vt;
	} fill_t;

	function automatic logic [MW-1:0] lvl_find(lvl_t l, logic [TW-1:0] tag);
		logic [MW-1:0] m;
		m = '0;
		for (int i = 0; i < MW; i++)
			m[i] = l.v[i] && (l.t[i] == tag);
		return m;
	endfunction

	function automatic logic [RW-1:0] rank_of(lvl_t l, logic [MW-1:0] m);
		logic [RW-1:0] r;
		r = '0;
		for (int i = 0; i < MW; i++)
			if (m[i]) r = r | l.r[i];
		return r;
	endfunction

	// move the selected entry to most recent
	function automatic lvl_t lvl_refresh(lvl_t l, logic [MW-1:0] m);
		lvl_t          o;
		logic [RW-1:0] r;
		o = l;
		r = rank_of(l, m);
		if (|m) begin
			for (int i = 0; i < MW; i++) begin
				if (l.v[i] && l.r[i] < r) o.r[i] = l.r[i] + RW'(1);
				if (m[i]) o.r[i] = '0;
			end
		end
		return o;
	endfunction

	function automatic lvl_t lvl_drop(lvl_t l, logic [MW-1:0] m);
		lvl_t          o;
		logic [RW-1:0] r;
		o = l;
		r = rank_of(l, m);
		if (|m) begin
			for (int i = 0; i < MW; i++) begin
				if (l.v[i] && l.r[i] > r) o.r[i] = l.r[i] - RW'(1);
				if (m[i]) begin
					o.v[i] = 1'b0;
					o.r[i] = '0;
				end
			end
		end
		return o;
	endfunction

	// insert an absent line; a full level first gives up its oldest entry
	function automatic fill_t lvl_fill(lvl_t l, logic [TW-1:0] tag, int ways);
		fill_t         f;
		lvl_t          o;
		logic          full;
		logic          found;
		logic [MW-1:0] vm;
		full  = 1'b1;
		found = 1'b0;
		vm    = '0;
		f.vt  = '0;
		for (int i = 0; i < MW; i++) begin
			if (i < ways) begin
				full = full & l.v[i];
				if (l.v[i] && l.r[i] == RW'(ways - 1)) vm[i] = 1'b1;
			end
		end
		if (!full) vm = '0;
		for (int i = 0; i < MW; i++)
			if (vm[i]) f.vt = f.vt | l.t[i];
		f.ev = full;
		o = lvl_drop(l, vm);
		for (int i = 0; i < MW; i++) begin
			if (o.v[i]) begin
				o.r[i] = o.r[i] + RW'(1);
			end else if (!found && i < ways) begin
				o.t[i] = tag;
				o.v[i] = 1'b1;
				o.r[i] = '0;
				found  = 1'b1;
			end
		end
		f.l = o;
		return f;
	endfunction

	// level storage: valid and rank reset, tags do not
	logic [NEAR_WAYS-1:0]          in_n_v_q, ex_n_v_q;
	logic [NEAR_WAYS-1:0][NRW-1:0] in_n_r_q, ex_n_r_q;
	logic [NEAR_WAYS-1:0][TW-1:0]  in_n_t_q, ex_n_t_q;
	logic [FAR_WAYS-1:0]           in_f_v_q, ex_f_v_q;
	logic [FAR_WAYS-1:0][FRW-1:0]  in_f_r_q, ex_f_r_q;
	logic [FAR_WAYS-1:0][TW-1:0]   in_f_t_q, ex_f_t_q;
	logic [CNT_W-1:0]              in_cnt_q, ex_cnt_q;

	logic          valid_s1, first_s1, last_s1;
	logic [TW-1:0] tag_s1;
	logic          advance, step;

	lvl_t          in_n_c, in_f_c, ex_n_c, ex_f_c;
	lvl_t          in_n_x, in_f_x, ex_n_x, ex_f_x;
	lvl_t          in_n_d, ex_f_d;
	fill_t         fill_in_f, fill_in_n, fill_ex_n, fill_ex_f;
	logic [MW-1:0] im_n, im_f, em_n, em_f;
	logic          incl_miss, excl_miss;
	logic [CNT_W-1:0] in_cnt_b, ex_cnt_b, in_cnt_d, ex_cnt_d;

	logic             ovalid_q, oim_q, oem_q, olast_q;
	logic [CNT_W-1:0] oitot_q, oetot_q;

	assign advance  = !ovalid_q || out.ready;
	assign step     = valid_s1 && advance;
	assign in.ready = !valid_s1 || advance;

	// widen stored levels; a first access sees empty levels
	always_comb begin
		in_n_c = '0;
		ex_n_c = '0;
		in_f_c = '0;
		ex_f_c = '0;
		for (int i = 0; i < NEAR_WAYS; i++) begin
			in_n_c.t[i] = in_n_t_q[i];
			ex_n_c.t[i] = ex_n_t_q[i];
			if (!first_s1) begin
				in_n_c.v[i] = in_n_v_q[i];
				in_n_c.r[i] = RW'(in_n_r_q[i]);
				ex_n_c.v[i] = ex_n_v_q[i];
				ex_n_c.r[i] = RW'(ex_n_r_q[i]);
			end
		end
		for (int i = 0; i < FAR_WAYS; i++) begin
			in_f_c.t[i] = in_f_t_q[i];
			ex_f_c.t[i] = ex_f_t_q[i];
			if (!first_s1) begin
				in_f_c.v[i] = in_f_v_q[i];
				in_f_c.r[i] = RW'(in_f_r_q[i]);
				ex_f_c.v[i] = ex_f_v_q[i];
				ex_f_c.r[i] = RW'(ex_f_r_q[i]);
			end
		end
	end

	// inclusive hierarchy
	always_comb begin
		im_n      = lvl_find(in_n_c, tag_s1);
		im_f      = lvl_find(in_f_c, tag_s1);
		fill_in_f = lvl_fill(in_f_c, tag_s1, FAR_WAYS);
		// back-invalidate the far victim before refilling near
		in_n_d    = fill_in_f.ev ? lvl_drop(in_n_c, lvl_find(in_n_c, fill_in_f.vt)) : in_n_c;
		incl_miss = 1'b0;
		if (|im_n) begin
			in_n_x = lvl_refresh(in_n_c, im_n);
			in_f_x = lvl_refresh(in_f_c, im_f);
			fill_in_n = lvl_fill(in_n_c, tag_s1, NEAR_WAYS);
		end else if (|im_f) begin
			in_f_x    = lvl_refresh(in_f_c, im_f);
			fill_in_n = lvl_fill(in_n_c, tag_s1, NEAR_WAYS);
			in_n_x    = fill_in_n.l;
		end else begin
			in_f_x    = fill_in_f.l;
			fill_in_n = lvl_fill(in_n_d, tag_s1, NEAR_WAYS);
			in_n_x    = fill_in_n.l;
			incl_miss = 1'b1;
		end
	end

	// exclusive hierarchy
	always_comb begin
		em_n      = lvl_find(ex_n_c, tag_s1);
		em_f      = lvl_find(ex_f_c, tag_s1);
		ex_f_d    = lvl_drop(ex_f_c, em_f);
		fill_ex_n = lvl_fill(ex_n_c, tag_s1, NEAR_WAYS);
		fill_ex_f = lvl_fill(ex_f_d, fill_ex_n.vt, FAR_WAYS);
		if (|em_n) begin
			ex_n_x    = lvl_refresh(ex_n_c, em_n);
			ex_f_x    = ex_f_c;
			excl_miss = 1'b0;
		end else begin
			ex_n_x    = fill_ex_n.l;
			ex_f_x    = fill_ex_n.ev ? fill_ex_f.l : ex_f_d;
			excl_miss = !(|em_f);
		end
	end

	always_comb begin
		in_cnt_b = first_s1 ? '0 : in_cnt_q;
		ex_cnt_b = first_s1 ? '0 : ex_cnt_q;
		in_cnt_d = (incl_miss && !(&in_cnt_b)) ? in_cnt_b + CNT_W'(1) : in_cnt_b;
		ex_cnt_d = (excl_miss && !(&ex_cnt_b)) ? ex_cnt_b + CNT_W'(1) : ex_cnt_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ovalid_q <= 1'b0;
			in_n_v_q <= '0;
			in_n_r_q <= '0;
			ex_n_v_q <= '0;
			ex_n_r_q <= '0;
			in_f_v_q <= '0;
			in_f_r_q <= '0;
			ex_f_v_q <= '0;
			ex_f_r_q <= '0;
			in_cnt_q <= '0;
			ex_cnt_q <= '0;
		end else begin
			if (in.valid && in.ready) valid_s1 <= 1'b1;
			else if (step) valid_s1 <= 1'b0;
			if (step) ovalid_q <= 1'b1;
			else if (out.ready) ovalid_q <= 1'b0;
			if (step) begin
				for (int i = 0; i < NEAR_WAYS; i++) begin
					in_n_v_q[i] <= in_n_x.v[i];
					in_n_r_q[i] <= NRW'(in_n_x.r[i]);
					ex_n_v_q[i] <= ex_n_x.v[i];
					ex_n_r_q[i] <= NRW'(ex_n_x.r[i]);
				end
				for (int i = 0; i < FAR_WAYS; i++) begin
					in_f_v_q[i] <= in_f_x.v[i];
					in_f_r_q[i] <= FRW'(in_f_x.r[i]);
					ex_f_v_q[i] <= ex_f_x.v[i];
					ex_f_r_q[i] <= FRW'(ex_f_x.r[i]);
				end
				in_cnt_q <= in_cnt_d;
				ex_cnt_q <= ex_cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			tag_s1   <= in.address[ADDR_BITS-1:LSH];
			first_s1 <= in.first_access;
			last_s1  <= in.last_access;
		end
		if (step) begin
			for (int i = 0; i < NEAR_WAYS; i++) begin
				in_n_t_q[i] <= in_n_x.t[i];
				ex_n_t_q[i] <= ex_n_x.t[i];
			end
			for (int i = 0; i < FAR_WAYS; i++) begin
				in_f_t_q[i] <= in_f_x.t[i];
				ex_f_t_q[i] <= ex_f_x.t[i];
			end
			oim_q   <= incl_miss;
			oem_q   <= excl_miss;
			oitot_q <= in_cnt_d;
			oetot_q <= ex_cnt_d;
			olast_q <= last_s1;
		end
	end

	assign out.valid           = ovalid_q;
	assign out.inclusive_miss  = oim_q;
	assign out.exclusive_miss  = oem_q;
	assign out.inclusive_total = oitot_q;
	assign out.exclusive_total = oetot_q;
	assign out.last_result     = olast_q;
endmodule

FILE: sv/tlh_check.sv
// Port-level checker for the LRU hierarchy miss counter, bound to the top level.
// Depends on tlh_pkg and the assertion macro header.
`include "two_level_lru_hierarchy_miss_counter_defines.svh"
module tlh_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      out_im,
	input logic                      out_em,
	input logic [tlh_pkg::CNT_W-1:0] out_itot,
	input logic [tlh_pkg::CNT_W-1:0] out_etot
);
	import tlh_pkg::*;

	// a stalled result keeps its transaction
	`TLH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_itot))
	// a miss is always part of its own running count
	`TLH_ASSERT_NOW(a_incl_count, out_valid && out_im, out_itot != '0)
	`TLH_ASSERT_NOW(a_excl_count, out_valid && out_em, out_etot != '0)
	// input stage is occupied after an accept, so a stalled output closes the input
	`TLH_ASSERT_NOW(a_backpressure,
		out_valid && !out_ready && $past(in_valid && in_ready), !in_ready)
endmodule

bind two_level_lru_hierarchy_miss_counter tlh_check u_tlh_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in.valid),
	.in_ready  (in.ready),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_im    (out.inclusive_miss),
	.out_em    (out.exclusive_miss),
	.out_itot  (out.inclusive_total),
	.out_etot  (out.exclusive_total)
);

FILE: sim/tb.sv
// Testbench of two_level_lru_hierarchy_miss_counter: drives access traces, predicts
// the inclusive and exclusive miss flags and running totals, and checks every result.
// Depends on tlh_pkg, tlh_if.sv and the RTL of the block.
module tb;
	import tlh_pkg::*;

	localparam int LINE_W = ADDR_BITS_DEF - 6;
	localparam int LIMIT = 400000;
	localparam int LV_IN_NEAR = 0, LV_IN_FAR = 1, LV_EX_NEAR = 2, LV_EX_FAR = 3;

	typedef struct packed {
		logic              inclusive_miss;
		logic              exclusive_miss;
		logic [CNT_W-1:0]  inclusive_total;
		logic [CNT_W-1:0]  exclusive_total;
		logic              last_result;
	} miss_report_t;

	logic clk = 0;
	logic arst_n = 0;
	tlh_in_if #(.AW(ADDR_BITS_DEF)) in_ch();
	tlh_out_if out_ch();

	two_level_lru_hierarchy_miss_counter uut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// mirror of the four LRU levels
	logic [LINE_W-1:0] line_tag [4][32];
	bit                line_vld [4][32];
	int                line_rank[4][32];
	logic [CNT_W-1:0]  incl_misses, excl_misses;

	miss_report_t report_q[$];
	int errors = 0, checked = 0, incl_seen = 0, excl_seen = 0;
	int send_idle = 0, recv_idle = 0, hold_left = 0;
	longint cycles = 0;

	function automatic int ways_of(int lv);
		return (lv == LV_IN_NEAR || lv == LV_EX_NEAR) ? NEAR_WAYS_DEF : FAR_WAYS_DEF;
	endfunction

	function automatic void clear_levels();
		for (int l = 0; l < 4; l++)
			for (int i = 0; i < 32; i++) begin
				line_vld[l][i] = 0;
				line_rank[l][i] = 0;
			end
		incl_misses = '0;
		excl_misses = '0;
	endfunction

	function automatic int find_line(int lv, logic [LINE_W-1:0] line);
		for (int i = 0; i < ways_of(lv); i++)
			if (line_vld[lv][i] && line_tag[lv][i] == line) return i;
		return -1;
	endfunction

	function automatic void touch(int lv, int slot);
		int r;
		if (slot < 0) return;
		r = line_rank[lv][slot];
		for (int i = 0; i < ways_of(lv); i++)
			if (line_vld[lv][i] && line_rank[lv][i] < r) line_rank[lv][i]++;
		line_rank[lv][slot] = 0;
	endfunction

	function automatic void evict(int lv, int slot);
		int r;
		if (slot < 0) return;
		r = line_rank[lv][slot];
		for (int i = 0; i < ways_of(lv); i++)
			if (line_vld[lv][i] && line_rank[lv][i] > r) line_rank[lv][i]--;
		line_vld[lv][slot] = 0;
		line_rank[lv][slot] = 0;
	endfunction

	// inserts an absent line; returns 1 with the displaced line when the level was full
	function automatic bit insert(int lv, logic [LINE_W-1:0] line,
			output logic [LINE_W-1:0] victim);
		int used, oldest, free_slot;
		bit displaced;
		used = 0;
		oldest = -1;
		free_slot = -1;
		displaced = 0;
		victim = '0;
		for (int i = 0; i < ways_of(lv); i++)
			if (line_vld[lv][i]) begin
				used++;
				if (oldest < 0 || line_rank[lv][i] > line_rank[lv][oldest]) oldest = i;
			end
		if (used >= ways_of(lv) && oldest >= 0) begin
			victim = line_tag[lv][oldest];
			displaced = 1;
			evict(lv, oldest);
		end
		for (int i = 0; i < ways_of(lv); i++)
			if (!line_vld[lv][i]) begin
				if (free_slot < 0) free_slot = i;
			end else
				line_rank[lv][i]++;
		if (free_slot >= 0) begin
			line_tag[lv][free_slot] = line;
			line_vld[lv][free_slot] = 1;
			line_rank[lv][free_slot] = 0;
		end
		return displaced;
	endfunction

	function automatic bit play_inclusive(logic [LINE_W-1:0] line);
		logic [LINE_W-1:0] victim;
		int hit;
		hit = find_line(LV_IN_NEAR, line);
		if (hit >= 0) begin
			touch(LV_IN_NEAR, hit);
			touch(LV_IN_FAR, find_line(LV_IN_FAR, line));
			return 0;
		end
		hit = find_line(LV_IN_FAR, line);
		if (hit >= 0) begin
			touch(LV_IN_FAR, hit);
			void'(insert(LV_IN_NEAR, line, victim));
			return 0;
		end
		// back-invalidate the far victim from the near level
		if (insert(LV_IN_FAR, line, victim))
			evict(LV_IN_NEAR, find_line(LV_IN_NEAR, victim));
		void'(insert(LV_IN_NEAR, line, victim));
		return 1;
	endfunction

	function automatic bit play_exclusive(logic [LINE_W-1:0] line);
		logic [LINE_W-1:0] victim, spill;
		int hit;
		hit = find_line(LV_EX_NEAR, line);
		if (hit >= 0) begin
			touch(LV_EX_NEAR, hit);
			return 0;
		end
		hit = find_line(LV_EX_FAR, line);
		evict(LV_EX_FAR, hit);
		if (insert(LV_EX_NEAR, line, victim))
			void'(insert(LV_EX_FAR, victim, spill));
		return hit < 0;
	endfunction

	function automatic miss_report_t predict_access(logic [ADDR_BITS_DEF-1:0] addr,
			logic first, logic last);
		miss_report_t r;
		logic [LINE_W-1:0] line;
		line = LINE_W'(addr / LINE_SIZE_DEF);
		if (first) clear_levels();
		r.inclusive_miss = play_inclusive(line);
		r.exclusive_miss = play_exclusive(line);
		if (r.inclusive_miss && incl_misses != '1) incl_misses++;
		if (r.exclusive_miss && excl_misses != '1) excl_misses++;
		r.inclusive_total = incl_misses;
		r.exclusive_total = excl_misses;
		r.last_result = last;
		return r;
	endfunction

	task automatic send_access(logic [ADDR_BITS_DEF-1:0] addr, logic first, logic last);
		in_ch.valid <= 1;
		in_ch.address <= addr;
		in_ch.first_access <= first;
		in_ch.last_access <= last;
		do @(posedge clk); while (!in_ch.ready);
		report_q.push_back(predict_access(addr, first, last));
		if ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic go_quiet();
		in_ch.valid <= 0;
		@(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [ADDR_BITS_DEF-1:0] addr_of(logic [LINE_W-1:0] line);
		return {line, 6'($urandom_range(63))};
	endfunction

	task automatic test_directed();
		logic [LINE_W-1:0] base;
		base = LINE_W'(42'h2A5_5A5A_5A5A);
		send_access('0, 1, 0);
		send_access('1, 0, 0);
		send_access('1, 0, 0);
		send_access(48'h0000_0000_003F, 0, 0);
		// nine lines overflow the near level, then revisit the displaced one
		for (int i = 0; i < 9; i++) send_access(addr_of(base + LINE_W'(i)), 0, 0);
		send_access(addr_of(base), 0, 0);
		// first mark mid-trace wipes everything, last mark only echoes
		send_access('1, 1, 1);
		send_access('1, 0, 1);
	endtask

	task automatic test_far_eviction();
		logic [LINE_W-1:0] base;
		base = LINE_W'({$urandom, $urandom});
		send_access(addr_of(base), 1, 0);
		for (int i = 1; i < 40; i++) send_access(addr_of(base + LINE_W'(i)), 0, 0);
		for (int i = 0; i < 12; i++) send_access(addr_of(base + LINE_W'(i)), 0, i == 11);
	endtask

	task automatic test_random_traces(int n_items);
		logic [LINE_W-1:0] pool[64];
		int sent, len, span;
		sent = 0;
		while (sent < n_items) begin
			foreach (pool[i]) pool[i] = LINE_W'({$urandom, $urandom});
			len = $urandom_range(20, 90);
			span = $urandom_range(6, 63);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 4)
					send_access(ADDR_BITS_DEF'({$urandom, $urandom}),
						$urandom_range(99) < 3, k == len - 1);
				else
					send_access(addr_of(pool[$urandom_range(span)]), k == 0, k == len - 1);
			end
			sent += len;
		end
	endtask

	task automatic test_backpressure();
		hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_access(addr_of(LINE_W'($urandom_range(50))), i == 0, i == 39);
	endtask

	initial begin
		in_ch.valid = 0;
		in_ch.address = '0;
		in_ch.first_access = 0;
		in_ch.last_access = 0;
		out_ch.ready = 0;
		clear_levels();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_idle = 16;
		recv_idle = 88;
		test_directed();
		test_far_eviction();
		test_random_traces(300);
		go_quiet();

		send_idle = 88;
		recv_idle = 16;
		test_random_traces(300);
		go_quiet();

		send_idle = 0;
		recv_idle = 0;
		test_backpressure();
		go_quiet();
		test_random_traces(400);
		go_quiet();
		repeat (10) @(posedge clk);

		$display("Checked %0d results over directed, random-trace and stall phases;", checked);
		$display("inclusive misses seen %0d, exclusive misses seen %0d, mismatches %0d.",
			incl_seen, excl_seen, errors);
		if (errors == 0 && report_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 0;
		end else
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		miss_report_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.inclusive_miss = out_ch.inclusive_miss;
			got.exclusive_miss = out_ch.exclusive_miss;
			got.inclusive_total = out_ch.inclusive_total;
			got.exclusive_total = out_ch.exclusive_total;
			got.last_result = out_ch.last_result;
			if (report_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transaction: %p", got);
			end else begin
				want = report_q.pop_front();
				checked++;
				incl_seen += want.inclusive_miss;
				excl_seen += want.exclusive_miss;
				if (got.inclusive_miss !== want.inclusive_miss
						|| got.exclusive_miss !== want.exclusive_miss
						|| got.inclusive_total !== want.inclusive_total
						|| got.exclusive_total !== want.exclusive_total
						|| got.last_result !== want.last_result) begin
					errors++;
					if (errors <= 10)
						$display("mismatch #%0d: expected %p, got %p", checked, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end
endmodule

FILE: two_level_lru_hierarchy_miss_counter.f
+incdir+sv
sv/tlh_pkg.sv
sv/tlh_if.sv
sv/two_level_lru_hierarchy_miss_counter.sv
sv/tlh_check.sv
sim/tb.sv
